@@ rtl/core/pactc_pkg.sv @@
package pactc_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned HALF_W  = 31;
	localparam int unsigned NORM_W  = 16;
	localparam int unsigned CORN_W  = COORD_W + 1;
	localparam int unsigned PROD_W  = NORM_W + CORN_W;
	localparam int unsigned PAIR_W  = PROD_W + 1;
	localparam int unsigned SUM_W   = PROD_W + 3;
	localparam int unsigned OFF_SH  = 15;
	localparam int unsigned ADDR_W  = 5;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned IN_TDATA_W  = 128;
	localparam int unsigned OUT_TDATA_W = 8;

	localparam logic [HALF_W-1:0] RADIUS_RESET = 31'd6881280;

	typedef enum logic [2:0] {
		REG_NORMAL_X     = 3'd0,
		REG_NORMAL_Y     = 3'd1,
		REG_NORMAL_Z     = 3'd2,
		REG_PLANE_OFFSET = 3'd3,
		REG_CENTER_X     = 3'd4,
		REG_CENTER_Y     = 3'd5,
		REG_CENTER_Z     = 3'd6,
		REG_RADIUS       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [NORM_W-1:0]  normal_x;
		logic signed [NORM_W-1:0]  normal_y;
		logic signed [NORM_W-1:0]  normal_z;
		logic signed [COORD_W-1:0] plane_offset;
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic [HALF_W-1:0]         radius;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cell_x;
		logic signed [COORD_W-1:0] cell_y;
		logic signed [COORD_W-1:0] cell_z;
		logic [HALF_W-1:0]         half_size;
	} cell_t;

endpackage

@@ rtl/core/pactc_regs.sv @@
module pactc_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pactc_pkg::ADDR_W-1:0]      paddr,
	input  logic [pactc_pkg::DATA_W-1:0]      pwdata,
	output logic [pactc_pkg::DATA_W-1:0]      prdata,
	output logic                              pready,
	output pactc_pkg::cfg_t                   cfg
);

	pactc_pkg::cfg_t      cfg_q;
	pactc_pkg::reg_idx_t  idx;
	logic                 wr_en;

	assign idx    = pactc_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_x     <= '0;
			cfg_q.normal_y     <= '0;
			cfg_q.normal_z     <= '0;
			cfg_q.plane_offset <= '0;
			cfg_q.center_x     <= '0;
			cfg_q.center_y     <= '0;
			cfg_q.center_z     <= '0;
			cfg_q.radius       <= pactc_pkg::RADIUS_RESET;
		end else if (wr_en) begin
			unique case (idx)
				pactc_pkg::REG_NORMAL_X:     cfg_q.normal_x     <= pwdata[15:0];
				pactc_pkg::REG_NORMAL_Y:     cfg_q.normal_y     <= pwdata[15:0];
				pactc_pkg::REG_NORMAL_Z:     cfg_q.normal_z     <= pwdata[15:0];
				pactc_pkg::REG_PLANE_OFFSET: cfg_q.plane_offset <= pwdata;
				pactc_pkg::REG_CENTER_X:     cfg_q.center_x     <= pwdata;
				pactc_pkg::REG_CENTER_Y:     cfg_q.center_y     <= pwdata;
				pactc_pkg::REG_CENTER_Z:     cfg_q.center_z     <= pwdata;
				pactc_pkg::REG_RADIUS:       cfg_q.radius       <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			pactc_pkg::REG_NORMAL_X:     prdata = {{16{cfg_q.normal_x[15]}}, cfg_q.normal_x};
			pactc_pkg::REG_NORMAL_Y:     prdata = {{16{cfg_q.normal_y[15]}}, cfg_q.normal_y};
			pactc_pkg::REG_NORMAL_Z:     prdata = {{16{cfg_q.normal_z[15]}}, cfg_q.normal_z};
			pactc_pkg::REG_PLANE_OFFSET: prdata = cfg_q.plane_offset;
			pactc_pkg::REG_CENTER_X:     prdata = cfg_q.center_x;
			pactc_pkg::REG_CENTER_Y:     prdata = cfg_q.center_y;
			pactc_pkg::REG_CENTER_Z:     prdata = cfg_q.center_z;
			pactc_pkg::REG_RADIUS:       prdata = {1'b0, cfg_q.radius};
			default:                     prdata = '0;
		endcase
	end

endmodule

@@ rtl/core/pactc_plane.sv @@
module pactc_plane (
	input  logic            clk,
	input  logic            en,
	input  pactc_pkg::cfg_t cfg,
	input  pactc_pkg::cell_t req,
	output logic            crossing
);

	localparam int unsigned CW = pactc_pkg::CORN_W;
	localparam int unsigned PW = pactc_pkg::PROD_W;
	localparam int unsigned AW = pactc_pkg::PAIR_W;
	localparam int unsigned SW = pactc_pkg::SUM_W;

	// [axis][0: centre - h, 1: centre + h]
	logic signed [CW-1:0] corn_s1 [3][2];
	logic signed [PW-1:0] prod_s2 [3][2];
	logic signed [AW-1:0] xy_s3 [4];
	logic signed [AW-1:0] zo_s3 [2];
	logic [7:1]           neg_s4;
	logic                 pos0_s4;
	logic                 cross_s5;

	logic signed [CW-1:0] ctr [3];
	logic signed [CW-1:0] half_w;
	logic signed [PW-1:0] nrm [3];
	logic signed [AW-1:0] off_w;
	logic signed [SW-1:0] v [8];

	assign ctr[0] = {req.cell_x[31], req.cell_x};
	assign ctr[1] = {req.cell_y[31], req.cell_y};
	assign ctr[2] = {req.cell_z[31], req.cell_z};
	assign half_w = {2'b00, req.half_size};
	assign nrm[0] = {{CW{cfg.normal_x[15]}}, cfg.normal_x};
	assign nrm[1] = {{CW{cfg.normal_y[15]}}, cfg.normal_y};
	assign nrm[2] = {{CW{cfg.normal_z[15]}}, cfg.normal_z};
	assign off_w  = {{(AW-pactc_pkg::COORD_W-pactc_pkg::OFF_SH){cfg.plane_offset[31]}},
		cfg.plane_offset, {pactc_pkg::OFF_SH{1'b0}}};

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			v[k] = SW'(xy_s3[k & 3]) + SW'(zo_s3[k >> 2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				corn_s1[a][0] <= ctr[a] - half_w;
				corn_s1[a][1] <= ctr[a] + half_w;
			end
			for (int a = 0; a < 3; a++) begin
				for (int s = 0; s < 2; s++) begin
					prod_s2[a][s] <= nrm[a] * PW'(corn_s1[a][s]);
				end
			end
			for (int j = 0; j < 4; j++) begin
				xy_s3[j] <= AW'(prod_s2[0][j & 1]) + AW'(prod_s2[1][j >> 1]);
			end
			for (int i = 0; i < 2; i++) begin
				zo_s3[i] <= AW'(prod_s2[2][i]) + off_w;
			end
			for (int k = 1; k < 8; k++) begin
				neg_s4[k] <= v[k][SW-1];
			end
			pos0_s4 <= !v[0][SW-1] && (v[0] != '0);
			cross_s5 <= |(~(neg_s4[7:1] ^ {7{pos0_s4}}));
		end
	end

	assign crossing = cross_s5;

endmodule

@@ rtl/core/pactc_region.sv @@
module pactc_region (
	input  logic             clk,
	input  logic             en,
	input  pactc_pkg::cfg_t  cfg,
	input  pactc_pkg::cell_t req,
	output logic             touch
);

	localparam int unsigned CW = pactc_pkg::CORN_W;

	logic signed [CW-1:0] clo_s1 [3];
	logic signed [CW-1:0] chi_s1 [3];
	logic signed [CW-1:0] rlo_s1 [3];
	logic signed [CW-1:0] rhi_s1 [3];
	logic                 touch_s2, touch_s3, touch_s4, touch_s5;

	logic signed [CW-1:0] ctr [3];
	logic signed [CW-1:0] rc [3];
	logic signed [CW-1:0] half_w;
	logic signed [CW-1:0] rad_w;
	logic [2:0]           outside;

	assign ctr[0] = {req.cell_x[31], req.cell_x};
	assign ctr[1] = {req.cell_y[31], req.cell_y};
	assign ctr[2] = {req.cell_z[31], req.cell_z};
	assign rc[0]  = {cfg.center_x[31], cfg.center_x};
	assign rc[1]  = {cfg.center_y[31], cfg.center_y};
	assign rc[2]  = {cfg.center_z[31], cfg.center_z};
	assign half_w = {2'b00, req.half_size};
	assign rad_w  = {2'b00, cfg.radius};

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			outside[a] = (chi_s1[a] < rlo_s1[a]) || (clo_s1[a] > rhi_s1[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				clo_s1[a] <= ctr[a] - half_w;
				chi_s1[a] <= ctr[a] + half_w;
				rlo_s1[a] <= rc[a] - rad_w;
				rhi_s1[a] <= rc[a] + rad_w;
			end
			touch_s2 <= ~|outside;
			touch_s3 <= touch_s2;
			touch_s4 <= touch_s3;
			touch_s5 <= touch_s4;
		end
	end

	assign touch = touch_s5;

endmodule

@@ rtl/core/plane_and_region_cell_test_core.sv @@
// An accepted request passes through stages s1 to s5 before its result is on m_tdata.
// Throughput: one request per cycle; the five-stage corner product/sum pipeline
// sets the latency and the whole pipeline holds while a result waits on m_tready.
// Reset: arst_n clears the stage valid bits and loads the register defaults
// (all zero, radius 105.0).
module plane_and_region_cell_test_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pactc_pkg::ADDR_W-1:0]        paddr,
	input  logic [pactc_pkg::DATA_W-1:0]        pwdata,
	output logic [pactc_pkg::DATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// cell_x[31:0], cell_y[63:32], cell_z[95:64], half_size[126:96], zero pad
	input  logic [pactc_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// plane_crosses_cell[0], cell_touches_region[1], zero pad
	output logic [pactc_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	pactc_pkg::cfg_t  cfg;
	pactc_pkg::cell_t req;
	logic             en;
	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic             crossing, touch;

	assign req = {s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[126:96]};

	assign en       = !v_s5 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s5;
	assign m_tdata  = {6'd0, touch, crossing};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	pactc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pactc_plane u_plane (
		.clk      (clk),
		.en       (en),
		.cfg      (cfg),
		.req      (req),
		.crossing (crossing)
	);

	pactc_region u_region (
		.clk   (clk),
		.en    (en),
		.cfg   (cfg),
		.req   (req),
		.touch (touch)
	);

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stage");

	a_valid_advances: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s4 |=> v_s5)
		else $error("valid lost between stages");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5}))
		else $error("pipeline moved during stall");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> v_s1)
		else $error("accepted request not in first stage");

endmodule
